>>> rtl/stereo_peak_meter_hold_falloff_assert.svh
// Assertion macros shared by the stereo peak meter RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef STEREO_PEAK_METER_HOLD_FALLOFF_ASSERT_SVH
`define STEREO_PEAK_METER_HOLD_FALLOFF_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset.
`define SPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while in reset.
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPM_ASSERT_NOW(label, ante, cons, msg)
`define SPM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/spm_pkg.sv
// Types and constants of the stereo peak meter.
// Depends on nothing; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps

package spm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 12;
    localparam int ELAPSED_W   = 20;
    localparam int RATE_W      = 10;
    localparam int HOLD_W      = 9;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int HOLD_ACC_W  = 32;
    localparam int HOLD_US_W   = 26;
    localparam int DROP_W      = 11;
    localparam int FRAC_W      = 16;
    localparam int MANT_W      = 31;
    localparam int SCALE_W     = 23;
    localparam int LOG_A_W     = 20;
    localparam int PROD_W      = LOG_A_W + SCALE_W;
    localparam int NUM_W       = 31;
    localparam int STEP_W      = 4;

    // 625000 = 8 * 78125. The numerator is shifted right by three and then
    // divided by 78125 as (n * 225179982) >> 44, exact for n below 2^27.
    localparam int FALLOFF_SHIFT = 3;
    localparam int RECIP_W       = 28;
    localparam int RECIP_SHIFT   = 44;
    localparam int RECIP_PROD_W  = NUM_W - FALLOFF_SHIFT + RECIP_W;

    typedef logic signed [LEVEL_W-1:0] level_t;

    localparam level_t                 LEVEL_FLOOR   = -12'sd1536;
    localparam logic [DROP_W-1:0]      LEVEL_MAG_MAX = 11'd1536;
    // 320 * log10(2) in Q16.
    localparam logic [SCALE_W-1:0]     LOG_SCALE_Q16 = 23'd6313057;
    localparam logic [STEP_W-1:0]      LOG_INT_MAX   = 4'd15;
    localparam logic [STEP_W-1:0]      SQUARE_LAST   = 4'd15;
    localparam logic [RECIP_W-1:0]     FALLOFF_RECIP = 28'd225179982;
    localparam logic [NUM_W-1:0]       FALLOFF_HALF  = 31'd312500;
    localparam logic [16:0]            HOLD_UNIT_US  = 17'd100000;
    localparam logic [RATE_W-1:0]      FALLOFF_RESET = 10'd133;
    localparam logic [HOLD_W-1:0]      HOLD_RESET    = 9'd16;

    localparam logic [CFG_INDEX_W-1:0] REG_FALLOFF_RATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME    = 1'd1;

    // Sequencing from the top level to the lanes and the timing unit.
    typedef struct packed {
        logic accept;
        logic last;
        logic commit;
    } spm_ctrl_t;

    // What the timing unit hands to every lane for the block-end update.
    typedef struct packed {
        logic                 done;
        logic [DROP_W-1:0]    drop;
        logic [HOLD_US_W-1:0] hold_us;
        logic [ELAPSED_W-1:0] elapsed;
    } spm_time_stat_t;

    // What one lane reports to the merging stage.
    typedef struct packed {
        logic   done;
        level_t bar_next;
        level_t peak_next;
    } spm_lane_stat_t;

endpackage

>>> rtl/spm_channels.sv
// Valid/ready channel interfaces for sample frames and meter results.
// Depends on spm_pkg.
`timescale 1ns / 1ps

interface spm_frame_if import spm_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_left;
    logic signed [SAMPLE_W-1:0]  sample_right;
    logic                        frame_last;
    logic        [ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, sample_left, sample_right, frame_last, elapsed_us,
                    input ready);
    modport sink   (input valid, sample_left, sample_right, frame_last, elapsed_us,
                    output ready);
endinterface

interface spm_meter_if import spm_pkg::*;;
    logic   valid;
    logic   ready;
    level_t bar_left;
    level_t bar_right;
    level_t peak_left;
    level_t peak_right;

    modport source (output valid, bar_left, bar_right, peak_left, peak_right,
                    input ready);
    modport sink   (input valid, bar_left, bar_right, peak_left, peak_right,
                    output ready);
endinterface

>>> rtl/spm_time.sv
// Shared timing unit: bar drop from elapsed time and fall-off rate, and the
// hold threshold in microseconds. Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_time import spm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  spm_ctrl_t            ctrl,
    input  logic [ELAPSED_W-1:0] elapsed_us,
    input  logic [RATE_W-1:0]    falloff_rate,
    input  logic [HOLD_W-1:0]    hold_time,
    output spm_time_stat_t       stat
);

    typedef enum logic [1:0] {T_IDLE, T_MUL, T_DIV, T_DONE} phase_t;

    phase_t                  phase_reg;
    logic [ELAPSED_W-1:0]    elapsed_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DROP_W-1:0]       quot_reg;
    logic [HOLD_US_W-1:0]    hold_us_reg;

    logic [NUM_W-1:0]        scaled;
    logic [RECIP_PROD_W-1:0] recip_prod;

    assign scaled = {11'b0, elapsed_reg} * {21'b0, falloff_rate};

    // Division by 625000: drop the three low bits, then multiply by the
    // reciprocal of 78125 and keep the quotient bits.
    assign recip_prod = {{RECIP_W{1'b0}}, num_reg[NUM_W-1:FALLOFF_SHIFT]}
                      * {{(NUM_W-FALLOFF_SHIFT){1'b0}}, FALLOFF_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= T_IDLE;
        end
        else
        begin
            case (phase_reg)
                T_IDLE:
                begin
                    if (ctrl.accept && ctrl.last)
                    begin
                        phase_reg <= T_MUL;
                    end
                end
                T_MUL:
                begin
                    phase_reg <= T_DIV;
                end
                T_DIV:
                begin
                    phase_reg <= T_DONE;
                end
                T_DONE:
                begin
                    if (ctrl.commit)
                    begin
                        phase_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == T_IDLE && ctrl.accept && ctrl.last)
        begin
            elapsed_reg <= elapsed_us;
        end
        if (phase_reg == T_MUL)
        begin
            num_reg     <= scaled + FALLOFF_HALF;
            hold_us_reg <= {17'b0, hold_time} * {9'b0, HOLD_UNIT_US};
        end
        if (phase_reg == T_DIV)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT +: DROP_W];
        end
    end

    assign stat.done    = (phase_reg == T_DONE);
    assign stat.drop    = (quot_reg > LEVEL_MAG_MAX) ? LEVEL_MAG_MAX : quot_reg;
    assign stat.hold_us = hold_us_reg;
    assign stat.elapsed = elapsed_reg;

endmodule

>>> rtl/spm_lane.sv
// One meter channel: running maximum, iterative log conversion, bar and
// peak state. Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_lane import spm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spm_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  spm_time_stat_t             tstat,
    output spm_lane_stat_t             stat
);

    typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQUARE, L_SCALE, L_DONE} phase_t;

    phase_t                 phase_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic [SAMPLE_W-1:0]    block_max_reg;
    level_t                 bar_reg;
    level_t                 peak_reg;
    logic [HOLD_ACC_W-1:0]  hold_reg;

    logic [SAMPLE_W-1:0]    m_reg;
    logic [MANT_W-1:0]      x_reg;
    logic [STEP_W-1:0]      exp_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic [SAMPLE_W:0]      mag_wide;
    logic [SAMPLE_W-1:0]    mag;
    logic [SAMPLE_W-1:0]    max_next;
    logic [STEP_W-1:0]      exp_val;
    logic [MANT_W-1:0]      x_base;
    logic [MANT_W-1:0]      x_norm;
    logic [2*MANT_W-1:0]    sq;
    logic [MANT_W:0]        sq_top;
    logic [LOG_A_W-1:0]     a_val;
    logic [PROD_W:0]        rounded;
    logic [LEVEL_W-1:0]     q_raw;
    logic [DROP_W-1:0]      q_clamp;
    level_t                 level;
    logic signed [LEVEL_W:0] bar_dec;
    level_t                 bar_floor;
    level_t                 bar_new;
    logic [HOLD_ACC_W:0]    hold_sum;
    logic [HOLD_ACC_W-1:0]  hold_sat;
    logic                   replace;
    level_t                 peak_new;
    logic [HOLD_ACC_W-1:0]  hold_new;

    // The most negative sample wraps to 0x8000, which is full scale.
    assign mag_wide = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                         : {1'b0, sample};
    assign mag      = mag_wide[SAMPLE_W-1:0];
    assign max_next = (mag > block_max_reg) ? mag : block_max_reg;

    always_comb
    begin
        exp_val = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (m_reg[i])
            begin
                exp_val = STEP_W'(i);
            end
        end
    end

    // Mantissa in Q30, leading one at bit 30.
    assign x_base = {m_reg, {(MANT_W-SAMPLE_W){1'b0}}};
    assign x_norm = x_base << (LOG_INT_MAX - exp_val);

    // One fraction bit of log2 per squaring.
    assign sq     = x_reg * x_reg;
    assign sq_top = sq[2*MANT_W-1:MANT_W-1];

    assign a_val  = {LOG_INT_MAX - exp_reg, {FRAC_W{1'b0}}} - {{STEP_W{1'b0}}, frac_reg};

    assign rounded = {1'b0, prod_reg} + ((PROD_W+1)'(1) << 31);
    assign q_raw   = rounded[PROD_W:32];
    assign q_clamp = (q_raw > {1'b0, LEVEL_MAG_MAX}) ? LEVEL_MAG_MAX : q_raw[DROP_W-1:0];
    assign level   = (m_reg == '0) ? LEVEL_FLOOR
                                   : level_t'(LEVEL_W'(0) - {1'b0, q_clamp});

    assign bar_dec   = {bar_reg[LEVEL_W-1], bar_reg} - $signed({2'b0, tstat.drop});
    assign bar_floor = (bar_dec < $signed({LEVEL_FLOOR[LEVEL_W-1], LEVEL_FLOOR}))
                       ? LEVEL_FLOOR : level_t'(bar_dec[LEVEL_W-1:0]);
    assign bar_new   = (level > bar_floor) ? level : bar_floor;

    assign hold_sum = {1'b0, hold_reg} + {{(HOLD_ACC_W+1-ELAPSED_W){1'b0}}, tstat.elapsed};
    assign hold_sat = hold_sum[HOLD_ACC_W] ? '1 : hold_sum[HOLD_ACC_W-1:0];
    assign replace  = (level > peak_reg)
                   || (hold_sat > {{(HOLD_ACC_W-HOLD_US_W){1'b0}}, tstat.hold_us});
    assign peak_new = replace ? level : peak_reg;
    assign hold_new = replace ? '0 : hold_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= L_IDLE;
            cnt_reg       <= '0;
            block_max_reg <= '0;
            bar_reg       <= LEVEL_FLOOR;
            peak_reg      <= LEVEL_FLOOR;
            hold_reg      <= '1;
        end
        else
        begin
            if (ctrl.accept)
            begin
                block_max_reg <= ctrl.last ? '0 : max_next;
            end
            case (phase_reg)
                L_IDLE:
                begin
                    if (ctrl.accept && ctrl.last)
                    begin
                        phase_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= L_SQUARE;
                end
                L_SQUARE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SQUARE_LAST)
                    begin
                        phase_reg <= L_SCALE;
                    end
                end
                L_SCALE:
                begin
                    phase_reg <= L_DONE;
                end
                L_DONE:
                begin
                    if (ctrl.commit)
                    begin
                        bar_reg   <= bar_new;
                        peak_reg  <= peak_new;
                        hold_reg  <= hold_new;
                        phase_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            L_IDLE:
            begin
                if (ctrl.accept && ctrl.last)
                begin
                    m_reg <= max_next;
                end
            end
            L_NORM:
            begin
                x_reg    <= x_norm;
                exp_reg  <= exp_val;
                frac_reg <= '0;
            end
            L_SQUARE:
            begin
                x_reg    <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                frac_reg <= {frac_reg[FRAC_W-2:0], sq_top[MANT_W]};
            end
            L_SCALE:
            begin
                prod_reg <= {{SCALE_W{1'b0}}, a_val} * {{LOG_A_W{1'b0}}, LOG_SCALE_Q16};
            end
            default:
            begin
            end
        endcase
    end

    assign stat.done      = (phase_reg == L_DONE);
    assign stat.bar_next  = bar_new;
    assign stat.peak_next = peak_new;

endmodule

>>> rtl/stereo_peak_meter_hold_falloff.sv
// Stereo peak meter with bar fall-off and peak hold, top level.
// Uses the channel lanes, the shared timing unit, spm_pkg and the interfaces.
//
// frames carries one stereo Q1.15 frame per request, with frame_last marking
// the last frame of a metering block and elapsed_us the time since the
// previous block end. A request with frame_last set yields exactly one
// request on meter, carrying both bars and both held peaks in 1/16 dB;
// other requests yield nothing. Frames that do not end a block are taken
// back to back, but after a frame_last request is accepted frames.ready
// stays low until the result is committed to the output register. The
// block-end work is paced by the 16-step log2 squaring loop that each lane
// runs on its own multiplier.
// cfg_write/cfg_index/cfg_data write fall-off rate and hold time; they must
// only be written while no block-end work is pending, which the block itself does not enforce.
// Reset clears the maxima, drops bars and peaks to -96 dB, marks the hold
// as expired and loads the default register values. A stalled meter receiver
// does not stop frames: the result sits in the output register, and only a
// second block end waits for it to be taken before it commits.
`timescale 1ns / 1ps
`include "stereo_peak_meter_hold_falloff_assert.svh"

module stereo_peak_meter_hold_falloff import spm_pkg::*;
#(
    parameter int CHANNEL_COUNT = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    spm_frame_if.sink              frames,
    spm_meter_if.source            meter,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LANES_MAX = 2;

    typedef enum logic {S_IDLE, S_BUSY} state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [RATE_W-1:0]   falloff_rate_reg;
    logic [HOLD_W-1:0]   hold_time_reg;
    logic                out_valid_reg;
    level_t              bar_reg   [LANES_MAX];
    level_t              peak_reg  [LANES_MAX];

    spm_ctrl_t                  ctrl;
    spm_time_stat_t             time_stat;
    logic signed [SAMPLE_W-1:0] samples   [LANES_MAX];
    logic [LANES_MAX-1:0]       lane_done;
    level_t                     bar_sel   [LANES_MAX];
    level_t                     peak_sel  [LANES_MAX];
    logic                       lanes_done;
    logic                       commit;

    assign samples[0] = frames.sample_left;
    assign samples[1] = frames.sample_right;

    // Frames are taken whenever no block end is being worked on.
    assign frames.ready = (state_reg == S_IDLE);

    // The merge commits once every lane and the timing unit are finished and
    // the output register is free or being emptied in this same cycle.
    assign lanes_done = &lane_done;
    assign commit     = (state_reg == S_BUSY) && lanes_done && time_stat.done
                     && (!out_valid_reg || meter.ready);

    assign ctrl.accept = frames.valid && frames.ready;
    assign ctrl.last   = frames.frame_last;
    assign ctrl.commit = commit;

    spm_time u_time (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .elapsed_us   (frames.elapsed_us),
        .falloff_rate (falloff_rate_reg),
        .hold_time    (hold_time_reg),
        .stat         (time_stat)
    );

    // One lane per active channel; an absent channel reads as -96 dB and
    // never holds up the merge.
    for (genvar c = 0; c < LANES_MAX; c++)
    begin : g_lane
        if (c < CHANNEL_COUNT)
        begin : g_on
            spm_lane_stat_t lane_stat;

            spm_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .sample (samples[c]),
                .tstat  (time_stat),
                .stat   (lane_stat)
            );

            assign lane_done[c] = lane_stat.done;
            assign bar_sel[c]   = lane_stat.bar_next;
            assign peak_sel[c]  = lane_stat.peak_next;
        end
        else
        begin : g_off
            assign lane_done[c] = 1'b1;
            assign bar_sel[c]   = LEVEL_FLOOR;
            assign peak_sel[c]  = LEVEL_FLOOR;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.accept && ctrl.last)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, the output register and the configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            falloff_rate_reg <= FALLOFF_RESET;
            hold_time_reg    <= HOLD_RESET;
            for (int c = 0; c < LANES_MAX; c++)
            begin
                bar_reg[c]  <= LEVEL_FLOOR;
                peak_reg[c] <= LEVEL_FLOOR;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                for (int c = 0; c < LANES_MAX; c++)
                begin
                    bar_reg[c]  <= bar_sel[c];
                    peak_reg[c] <= peak_sel[c];
                end
            end
            else if (meter.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FALLOFF_RATE: falloff_rate_reg <= cfg_data[RATE_W-1:0];
                    REG_HOLD_TIME:    hold_time_reg    <= cfg_data[HOLD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign meter.valid      = out_valid_reg;
    assign meter.bar_left   = bar_reg[0];
    assign meter.bar_right  = bar_reg[1];
    assign meter.peak_left  = peak_reg[0];
    assign meter.peak_right = peak_reg[1];

    // A commit only happens with every lane and the timing unit finished.
    `SPM_ASSERT_NOW(a_commit_all_done, commit, lanes_done && time_stat.done, "commit before lanes finished")
    // A commit always presents a result in the next cycle.
    `SPM_ASSERT_NEXT(a_commit_shows, commit, meter.valid, "committed result not shown")
    // The timing unit finishes only for a block end in progress.
    `SPM_ASSERT_NOW(a_time_in_busy, time_stat.done, state_reg == S_BUSY, "timing done while idle")
    // Left levels stay in the -96..0 dB range.
    `SPM_ASSERT_NOW(a_left_range, meter.valid, (meter.bar_left <= 12'sd0) && (meter.bar_left >= LEVEL_FLOOR) && (meter.peak_left <= 12'sd0) && (meter.peak_left >= LEVEL_FLOOR), "left level out of range")

endmodule
